@@ design/pimrp_pkg.sv @@
// Shared constants, codes and the microcode table of the point-in-mesh ray-parity classifier.
// Used by point_in_mesh_ray_parity and its checker; depends on nothing else.
package pimrp_pkg;

  localparam int COORD_BITS = 32;
  localparam int TOL_BITS   = 31;
  localparam int YW         = COORD_BITS + 1;
  localparam int ACC_W      = 3 * COORD_BITS + 8;
  localparam int RAM_DEPTH  = 32;
  localparam int RA_W       = $clog2(RAM_DEPTH);
  localparam int NSTEP      = 71;
  localparam int STEP_W     = $clog2(NSTEP);
  localparam int BIT_W      = $clog2(YW + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CLASS_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_POINT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL     = 2'd3;

  localparam logic [CLASS_W-1:0] CLASS_BOUNDARY = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_INSIDE   = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_OUTSIDE  = 2'd2;

  localparam logic [TOL_BITS-1:0] TOL_RESET = 31'd66;

  // Scratch memory map.
  localparam logic [RA_W-1:0] A_P0  = 5'd0;
  localparam logic [RA_W-1:0] A_P1  = 5'd1;
  localparam logic [RA_W-1:0] A_P2  = 5'd2;
  localparam logic [RA_W-1:0] A_A0  = 5'd3;
  localparam logic [RA_W-1:0] A_A1  = 5'd4;
  localparam logic [RA_W-1:0] A_A2  = 5'd5;
  localparam logic [RA_W-1:0] A_B0  = 5'd6;
  localparam logic [RA_W-1:0] A_B1  = 5'd7;
  localparam logic [RA_W-1:0] A_B2  = 5'd8;
  localparam logic [RA_W-1:0] A_C0  = 5'd9;
  localparam logic [RA_W-1:0] A_C1  = 5'd10;
  localparam logic [RA_W-1:0] A_C2  = 5'd11;
  localparam logic [RA_W-1:0] A_TOL = 5'd12;
  localparam logic [RA_W-1:0] A_E10 = 5'd13;
  localparam logic [RA_W-1:0] A_E11 = 5'd14;
  localparam logic [RA_W-1:0] A_E12 = 5'd15;
  localparam logic [RA_W-1:0] A_E20 = 5'd16;
  localparam logic [RA_W-1:0] A_E21 = 5'd17;
  localparam logic [RA_W-1:0] A_E22 = 5'd18;
  localparam logic [RA_W-1:0] A_S0  = 5'd19;
  localparam logic [RA_W-1:0] A_S1  = 5'd20;
  localparam logic [RA_W-1:0] A_S2  = 5'd21;
  localparam logic [RA_W-1:0] A_D10 = 5'd22;
  localparam logic [RA_W-1:0] A_D11 = 5'd23;
  localparam logic [RA_W-1:0] A_D12 = 5'd24;
  localparam logic [RA_W-1:0] A_D20 = 5'd25;
  localparam logic [RA_W-1:0] A_D21 = 5'd26;
  localparam logic [RA_W-1:0] A_D22 = 5'd27;
  localparam logic [RA_W-1:0] A_H0  = 5'd28;
  localparam logic [RA_W-1:0] A_H1  = 5'd29;
  localparam logic [RA_W-1:0] A_H2  = 5'd30;
  localparam logic [RA_W-1:0] A_Q0  = 5'd3;
  localparam logic [RA_W-1:0] A_Q1  = 5'd4;
  localparam logic [RA_W-1:0] A_Q2  = 5'd5;
  localparam logic [RA_W-1:0] A_AR  = 5'd6;
  localparam logic [RA_W-1:0] A_UU  = 5'd7;
  localparam logic [RA_W-1:0] A_VV  = 5'd8;

  localparam logic [7:0] K1   = 8'd1;
  localparam logic [7:0] K10  = 8'd10;
  localparam logic [7:0] K100 = 8'd100;

  typedef enum logic [2:0] {
    CHK_NONE,
    CHK_NEAR,
    CHK_A,
    CHK_GE,
    CHK_GT
  } chk_e;

  typedef struct packed {
    logic [RA_W-1:0]  xa;
    logic             y_ram;
    logic [RA_W-1:0]  ya;
    logic [7:0]       yc;
    logic [BIT_W-1:0] ybits;
    logic             neg;
    logic             first;
    logic             last;
    logic             wr;
    logic [RA_W-1:0]  dst;
    chk_e             chk;
  } step_t;

  function automatic step_t mk_r(input logic [RA_W-1:0] xa, input logic [RA_W-1:0] ya,
                                 input logic neg, input logic first, input logic last,
                                 input logic wr, input logic [RA_W-1:0] dst, input chk_e chk);
    step_t s;
    s.xa    = xa;
    s.y_ram = 1'b1;
    s.ya    = ya;
    s.yc    = 8'd0;
    s.ybits = BIT_W'(YW);
    s.neg   = neg;
    s.first = first;
    s.last  = last;
    s.wr    = wr;
    s.dst   = dst;
    s.chk   = chk;
    return s;
  endfunction

  function automatic step_t mk_c(input logic [RA_W-1:0] xa, input logic [7:0] k,
                                 input logic neg, input logic first, input logic last,
                                 input logic wr, input logic [RA_W-1:0] dst, input chk_e chk);
    step_t s;
    s.xa    = xa;
    s.y_ram = 1'b0;
    s.ya    = xa;
    s.yc    = k;
    if (k == K100) begin
      s.ybits = BIT_W'(8);
    end else if (k == K10) begin
      s.ybits = BIT_W'(5);
    end else begin
      s.ybits = BIT_W'(2);
    end
    s.neg   = neg;
    s.first = first;
    s.last  = last;
    s.wr    = wr;
    s.dst   = dst;
    s.chk   = chk;
    return s;
  endfunction

  // Each step adds or subtracts one product to the accumulator.
  function automatic step_t step_rom(input logic [STEP_W-1:0] idx);
    step_t s;
    case (idx)
      7'd0:  s = mk_c(A_B0, K1, 1'b0, 1'b1, 1'b0, 1'b0, A_E10, CHK_NONE);
      7'd1:  s = mk_c(A_A0, K1, 1'b1, 1'b0, 1'b1, 1'b1, A_E10, CHK_NONE);
      7'd2:  s = mk_c(A_B1, K1, 1'b0, 1'b1, 1'b0, 1'b0, A_E11, CHK_NONE);
      7'd3:  s = mk_c(A_A1, K1, 1'b1, 1'b0, 1'b1, 1'b1, A_E11, CHK_NONE);
      7'd4:  s = mk_c(A_B2, K1, 1'b0, 1'b1, 1'b0, 1'b0, A_E12, CHK_NONE);
      7'd5:  s = mk_c(A_A2, K1, 1'b1, 1'b0, 1'b1, 1'b1, A_E12, CHK_NONE);
      7'd6:  s = mk_c(A_C0, K1, 1'b0, 1'b1, 1'b0, 1'b0, A_E20, CHK_NONE);
      7'd7:  s = mk_c(A_A0, K1, 1'b1, 1'b0, 1'b1, 1'b1, A_E20, CHK_NONE);
      7'd8:  s = mk_c(A_C1, K1, 1'b0, 1'b1, 1'b0, 1'b0, A_E21, CHK_NONE);
      7'd9:  s = mk_c(A_A1, K1, 1'b1, 1'b0, 1'b1, 1'b1, A_E21, CHK_NONE);
      7'd10: s = mk_c(A_C2, K1, 1'b0, 1'b1, 1'b0, 1'b0, A_E22, CHK_NONE);
      7'd11: s = mk_c(A_A2, K1, 1'b1, 1'b0, 1'b1, 1'b1, A_E22, CHK_NONE);
      7'd12: s = mk_c(A_P0, K1, 1'b0, 1'b1, 1'b0, 1'b0, A_S0, CHK_NONE);
      7'd13: s = mk_c(A_A0, K1, 1'b1, 1'b0, 1'b1, 1'b1, A_S0, CHK_NONE);
      7'd14: s = mk_c(A_P1, K1, 1'b0, 1'b1, 1'b0, 1'b0, A_S1, CHK_NONE);
      7'd15: s = mk_c(A_A1, K1, 1'b1, 1'b0, 1'b1, 1'b1, A_S1, CHK_NONE);
      7'd16: s = mk_c(A_P2, K1, 1'b0, 1'b1, 1'b0, 1'b0, A_S2, CHK_NONE);
      7'd17: s = mk_c(A_A2, K1, 1'b1, 1'b0, 1'b1, 1'b1, A_S2, CHK_NONE);
      7'd18: s = mk_c(A_P0, K1, 1'b0, 1'b1, 1'b0, 1'b0, A_D10, CHK_NONE);
      7'd19: s = mk_c(A_B0, K1, 1'b1, 1'b0, 1'b1, 1'b1, A_D10, CHK_NONE);
      7'd20: s = mk_c(A_P1, K1, 1'b0, 1'b1, 1'b0, 1'b0, A_D11, CHK_NONE);
      7'd21: s = mk_c(A_B1, K1, 1'b1, 1'b0, 1'b1, 1'b1, A_D11, CHK_NONE);
      7'd22: s = mk_c(A_P2, K1, 1'b0, 1'b1, 1'b0, 1'b0, A_D12, CHK_NONE);
      7'd23: s = mk_c(A_B2, K1, 1'b1, 1'b0, 1'b1, 1'b1, A_D12, CHK_NONE);
      7'd24: s = mk_c(A_P0, K1, 1'b0, 1'b1, 1'b0, 1'b0, A_D20, CHK_NONE);
      7'd25: s = mk_c(A_C0, K1, 1'b1, 1'b0, 1'b1, 1'b1, A_D20, CHK_NONE);
      7'd26: s = mk_c(A_P1, K1, 1'b0, 1'b1, 1'b0, 1'b0, A_D21, CHK_NONE);
      7'd27: s = mk_c(A_C1, K1, 1'b1, 1'b0, 1'b1, 1'b1, A_D21, CHK_NONE);
      7'd28: s = mk_c(A_P2, K1, 1'b0, 1'b1, 1'b0, 1'b0, A_D22, CHK_NONE);
      7'd29: s = mk_c(A_C2, K1, 1'b1, 1'b0, 1'b1, 1'b1, A_D22, CHK_NONE);
      7'd30: s = mk_c(A_E22, K10,  1'b0, 1'b1, 1'b0, 1'b0, A_H0, CHK_NONE);
      7'd31: s = mk_c(A_E21, K1,   1'b1, 1'b0, 1'b1, 1'b1, A_H0, CHK_NONE);
      7'd32: s = mk_c(A_E20, K1,   1'b0, 1'b1, 1'b0, 1'b0, A_H1, CHK_NONE);
      7'd33: s = mk_c(A_E22, K100, 1'b1, 1'b0, 1'b1, 1'b1, A_H1, CHK_NONE);
      7'd34: s = mk_c(A_E21, K100, 1'b0, 1'b1, 1'b0, 1'b0, A_H2, CHK_NONE);
      7'd35: s = mk_c(A_E20, K10,  1'b1, 1'b0, 1'b1, 1'b1, A_H2, CHK_NONE);
      7'd36: s = mk_r(A_S0, A_S0, 1'b0, 1'b1, 1'b0, 1'b0, A_S0, CHK_NONE);
      7'd37: s = mk_r(A_S1, A_S1, 1'b0, 1'b0, 1'b0, 1'b0, A_S0, CHK_NONE);
      7'd38: s = mk_r(A_S2, A_S2, 1'b0, 1'b0, 1'b0, 1'b0, A_S0, CHK_NONE);
      7'd39: s = mk_r(A_TOL, A_TOL, 1'b1, 1'b0, 1'b1, 1'b0, A_S0, CHK_NEAR);
      7'd40: s = mk_r(A_D10, A_D10, 1'b0, 1'b1, 1'b0, 1'b0, A_S0, CHK_NONE);
      7'd41: s = mk_r(A_D11, A_D11, 1'b0, 1'b0, 1'b0, 1'b0, A_S0, CHK_NONE);
      7'd42: s = mk_r(A_D12, A_D12, 1'b0, 1'b0, 1'b0, 1'b0, A_S0, CHK_NONE);
      7'd43: s = mk_r(A_TOL, A_TOL, 1'b1, 1'b0, 1'b1, 1'b0, A_S0, CHK_NEAR);
      7'd44: s = mk_r(A_D20, A_D20, 1'b0, 1'b1, 1'b0, 1'b0, A_S0, CHK_NONE);
      7'd45: s = mk_r(A_D21, A_D21, 1'b0, 1'b0, 1'b0, 1'b0, A_S0, CHK_NONE);
      7'd46: s = mk_r(A_D22, A_D22, 1'b0, 1'b0, 1'b0, 1'b0, A_S0, CHK_NONE);
      7'd47: s = mk_r(A_TOL, A_TOL, 1'b1, 1'b0, 1'b1, 1'b0, A_S0, CHK_NEAR);
      7'd48: s = mk_r(A_H0, A_E10, 1'b0, 1'b1, 1'b0, 1'b0, A_AR, CHK_NONE);
      7'd49: s = mk_r(A_H1, A_E11, 1'b0, 1'b0, 1'b0, 1'b0, A_AR, CHK_NONE);
      7'd50: s = mk_r(A_H2, A_E12, 1'b0, 1'b0, 1'b1, 1'b1, A_AR, CHK_A);
      7'd51: s = mk_r(A_H0, A_S0, 1'b0, 1'b1, 1'b0, 1'b0, A_UU, CHK_NONE);
      7'd52: s = mk_r(A_H1, A_S1, 1'b0, 1'b0, 1'b0, 1'b0, A_UU, CHK_NONE);
      7'd53: s = mk_r(A_H2, A_S2, 1'b0, 1'b0, 1'b1, 1'b1, A_UU, CHK_GE);
      7'd54: s = mk_r(A_S1, A_E12, 1'b0, 1'b1, 1'b0, 1'b0, A_Q0, CHK_NONE);
      7'd55: s = mk_r(A_S2, A_E11, 1'b1, 1'b0, 1'b1, 1'b1, A_Q0, CHK_NONE);
      7'd56: s = mk_r(A_S2, A_E10, 1'b0, 1'b1, 1'b0, 1'b0, A_Q1, CHK_NONE);
      7'd57: s = mk_r(A_S0, A_E12, 1'b1, 1'b0, 1'b1, 1'b1, A_Q1, CHK_NONE);
      7'd58: s = mk_r(A_S0, A_E11, 1'b0, 1'b1, 1'b0, 1'b0, A_Q2, CHK_NONE);
      7'd59: s = mk_r(A_S1, A_E10, 1'b1, 1'b0, 1'b1, 1'b1, A_Q2, CHK_NONE);
      7'd60: s = mk_c(A_Q0, K100, 1'b0, 1'b1, 1'b0, 1'b0, A_VV, CHK_NONE);
      7'd61: s = mk_c(A_Q1, K10,  1'b0, 1'b0, 1'b0, 1'b0, A_VV, CHK_NONE);
      7'd62: s = mk_c(A_Q2, K1,   1'b0, 1'b0, 1'b1, 1'b1, A_VV, CHK_GE);
      7'd63: s = mk_r(A_Q0, A_E20, 1'b0, 1'b1, 1'b0, 1'b0, A_S0, CHK_NONE);
      7'd64: s = mk_r(A_Q1, A_E21, 1'b0, 1'b0, 1'b0, 1'b0, A_S0, CHK_NONE);
      7'd65: s = mk_r(A_Q2, A_E22, 1'b0, 1'b0, 1'b1, 1'b0, A_S0, CHK_GT);
      7'd66: s = mk_c(A_AR, K1, 1'b0, 1'b1, 1'b0, 1'b0, A_S0, CHK_NONE);
      7'd67: s = mk_c(A_UU, K1, 1'b1, 1'b0, 1'b1, 1'b0, A_S0, CHK_GE);
      7'd68: s = mk_c(A_AR, K1, 1'b0, 1'b1, 1'b0, 1'b0, A_S0, CHK_NONE);
      7'd69: s = mk_c(A_UU, K1, 1'b1, 1'b0, 1'b0, 1'b0, A_S0, CHK_NONE);
      7'd70: s = mk_c(A_VV, K1, 1'b1, 1'b0, 1'b1, 1'b0, A_S0, CHK_GE);
      default: s = mk_c(A_P0, K1, 1'b0, 1'b1, 1'b1, 1'b0, A_P0, CHK_NONE);
    endcase
    return s;
  endfunction

endpackage

@@ design/pimrp_ram.sv @@
// Generic scratch RAM: one write port and two read ports with registered read data.
// Depends on nothing.
module pimrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wa_i,
  input  logic [WIDTH-1:0]         wd_i,
  input  logic [$clog2(DEPTH)-1:0] ra0_i,
  input  logic [$clog2(DEPTH)-1:0] ra1_i,
  output logic [WIDTH-1:0]         rd0_o,
  output logic [WIDTH-1:0]         rd1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wa_i] <= wd_i;
    end
    rd0_o <= mem_q[ra0_i];
    rd1_o <= mem_q[ra1_i];
  end

endmodule

@@ design/point_in_mesh_ray_parity.sv @@
// Top level of the point-in-mesh ray-parity classifier.
// Depends on pimrp_pkg and pimrp_ram.
//
// An item that carries a triangle keeps in_stall_o high after its transfer until its test is done.
// An item that closes the query then waits in S_EMIT to emit the result, longer while an earlier
// result still waits under out_stall_i. An item without a triangle that does not close the
// query is taken with no stall. The stall is set by the single bit-serial
// multiply-accumulate unit: the test runs as 71 microcode steps on a 32-entry scratch RAM,
// each step passing through issue and fetch and then through the multiplier bits (33 for
// products of two coordinates), after the point, vertices and tolerance are loaded, and
// before a tally state that updates the parity.
module point_in_mesh_ray_parity (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pimrp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pimrp_pkg::COORD_BITS-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                has_triangle_i,
  input  logic signed [pimrp_pkg::COORD_BITS-1:0] a_x_i,
  input  logic signed [pimrp_pkg::COORD_BITS-1:0] a_y_i,
  input  logic signed [pimrp_pkg::COORD_BITS-1:0] a_z_i,
  input  logic signed [pimrp_pkg::COORD_BITS-1:0] b_x_i,
  input  logic signed [pimrp_pkg::COORD_BITS-1:0] b_y_i,
  input  logic signed [pimrp_pkg::COORD_BITS-1:0] b_z_i,
  input  logic signed [pimrp_pkg::COORD_BITS-1:0] c_x_i,
  input  logic signed [pimrp_pkg::COORD_BITS-1:0] c_y_i,
  input  logic signed [pimrp_pkg::COORD_BITS-1:0] c_z_i,
  input  logic                                last_triangle_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pimrp_pkg::CLASS_W-1:0]       classification_o
);
  import pimrp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_ITER  = 3'd4;
  localparam logic [2:0] S_TALLY = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state_q, state_d;

  logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
  logic [TOL_BITS-1:0]          tol_q;

  logic signed [COORD_BITS-1:0] vax_q, vay_q, vaz_q, vbx_q, vby_q, vbz_q, vcx_q, vcy_q, vcz_q;
  logic                         last_q, last_d;

  logic [STEP_W-1:0] step_q, step_d;
  logic [RA_W-1:0]   ld_cnt_q, ld_cnt_d;
  logic [BIT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic [ACC_W-1:0]  acc_q, acc_d, m_q, m_d;
  logic [YW-1:0]     y_q, y_d;
  logic              ok_q, ok_d, a_neg_q, a_neg_d, a_zero_q, a_zero_d;
  logic              near_q, near_d, par_q, par_d;
  logic              out_valid_q, out_valid_d;
  logic [CLASS_W-1:0] class_q, class_d;

  step_t            st;
  logic             in_fire, iter_last, sub, res_neg, res_zero;
  logic [ACC_W-1:0] acc_sum, ld_data, rd_x, rd_y, ram_wd;
  logic             ram_we;
  logic [RA_W-1:0]  ram_wa;

  assign st          = step_rom(step_q);
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign classification_o = class_q;

  assign iter_last = (bit_cnt_q == (st.ybits - BIT_W'(1)));
  assign sub       = st.neg ^ iter_last;
  assign acc_sum   = y_q[0] ? (sub ? (acc_q - m_q) : (acc_q + m_q)) : acc_q;
  assign res_neg   = acc_sum[ACC_W-1];
  assign res_zero  = (acc_sum == '0);

  always_comb begin
    case (ld_cnt_q)
      A_P0:    ld_data = ACC_W'(px_q);
      A_P1:    ld_data = ACC_W'(py_q);
      A_P2:    ld_data = ACC_W'(pz_q);
      A_A0:    ld_data = ACC_W'(vax_q);
      A_A1:    ld_data = ACC_W'(vay_q);
      A_A2:    ld_data = ACC_W'(vaz_q);
      A_B0:    ld_data = ACC_W'(vbx_q);
      A_B1:    ld_data = ACC_W'(vby_q);
      A_B2:    ld_data = ACC_W'(vbz_q);
      A_C0:    ld_data = ACC_W'(vcx_q);
      A_C1:    ld_data = ACC_W'(vcy_q);
      A_C2:    ld_data = ACC_W'(vcz_q);
      default: ld_data = ACC_W'(tol_q);
    endcase
  end

  assign ram_we = (state_q == S_LOAD) ||
                  ((state_q == S_ITER) && iter_last && st.last && st.wr);
  assign ram_wa = (state_q == S_LOAD) ? ld_cnt_q : st.dst;
  assign ram_wd = (state_q == S_LOAD) ? ld_data : acc_sum;

  pimrp_ram #(
    .WIDTH(ACC_W),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk_i (clk_i),
    .we_i  (ram_we),
    .wa_i  (ram_wa),
    .wd_i  (ram_wd),
    .ra0_i (st.xa),
    .ra1_i (st.ya),
    .rd0_o (rd_x),
    .rd1_o (rd_y)
  );

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    step_d      = step_q;
    ld_cnt_d    = ld_cnt_q;
    bit_cnt_d   = bit_cnt_q;
    acc_d       = acc_q;
    m_d         = m_q;
    y_d         = y_q;
    ok_d        = ok_q;
    a_neg_d     = a_neg_q;
    a_zero_d    = a_zero_q;
    near_d      = near_q;
    par_d       = par_q;
    out_valid_d = out_valid_q && out_stall_i;
    class_d     = class_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          last_d = last_triangle_i;
          if (has_triangle_i) begin
            ok_d     = 1'b1;
            ld_cnt_d = '0;
            step_d   = '0;
            state_d  = S_LOAD;
          end else if (last_triangle_i) begin
            state_d = S_EMIT;
          end
        end
      end
      S_LOAD: begin
        ld_cnt_d = ld_cnt_q + RA_W'(1);
        if (ld_cnt_q == A_TOL) begin
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        state_d = S_FETCH;
      end
      S_FETCH: begin
        acc_d     = st.first ? '0 : acc_q;
        m_d       = rd_x;
        y_d       = st.y_ram ? rd_y[YW-1:0] : YW'(st.yc);
        bit_cnt_d = '0;
        state_d   = S_ITER;
      end
      S_ITER: begin
        acc_d     = acc_sum;
        m_d       = {m_q[ACC_W-2:0], 1'b0};
        y_d       = {1'b0, y_q[YW-1:1]};
        bit_cnt_d = bit_cnt_q + BIT_W'(1);
        if (iter_last) begin
          if (st.last) begin
            case (st.chk)
              CHK_NEAR: begin
                if (res_neg) begin
                  near_d = 1'b1;
                end
              end
              CHK_A: begin
                a_neg_d  = res_neg;
                a_zero_d = res_zero;
              end
              CHK_GE: begin
                if (!(res_zero || (res_neg == a_neg_q))) begin
                  ok_d = 1'b0;
                end
              end
              CHK_GT: begin
                if (res_zero || (res_neg != a_neg_q)) begin
                  ok_d = 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
          if (step_q == STEP_W'(NSTEP - 1)) begin
            state_d = S_TALLY;
          end else begin
            step_d  = step_q + STEP_W'(1);
            state_d = S_ISSUE;
          end
        end
      end
      S_TALLY: begin
        par_d   = par_q ^ (ok_q && !a_zero_q);
        state_d = last_q ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          class_d     = near_q ? CLASS_BOUNDARY : (par_q ? CLASS_INSIDE : CLASS_OUTSIDE);
          near_d      = 1'b0;
          par_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      px_q        <= '0;
      py_q        <= '0;
      pz_q        <= '0;
      tol_q       <= TOL_RESET;
      near_q      <= 1'b0;
      par_q       <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      ld_cnt_q    <= '0;
      bit_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      near_q      <= near_d;
      par_q       <= par_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      ld_cnt_q    <= ld_cnt_d;
      bit_cnt_q   <= bit_cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_POINT_X: px_q  <= cfg_data_i;
          CFG_POINT_Y: py_q  <= cfg_data_i;
          CFG_POINT_Z: pz_q  <= cfg_data_i;
          CFG_TOL:     tol_q <= cfg_data_i[TOL_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      vax_q <= a_x_i;
      vay_q <= a_y_i;
      vaz_q <= a_z_i;
      vbx_q <= b_x_i;
      vby_q <= b_y_i;
      vbz_q <= b_z_i;
      vcx_q <= c_x_i;
      vcy_q <= c_y_i;
      vcz_q <= c_z_i;
    end
    last_q   <= last_d;
    acc_q    <= acc_d;
    m_q      <= m_d;
    y_q      <= y_d;
    ok_q     <= ok_d;
    a_neg_q  <= a_neg_d;
    a_zero_q <= a_zero_d;
    class_q  <= class_d;
  end

endmodule

@@ design/pimrp_chk.sv @@
// Port-level checker for point_in_mesh_ray_parity, attached by the bind at the end.
// Depends on pimrp_pkg.
module pimrp_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            has_triangle_i,
  input logic                            last_triangle_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [pimrp_pkg::CLASS_W-1:0]   classification_o
);
  import pimrp_pkg::*;

  // A transfer without a triangle and not closing the query leaves the block ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !has_triangle_i && !last_triangle_i) |=> !in_stall_o)
    else $error("block not ready after an empty transfer");

  // A transfer with a triangle starts the multi-cycle test.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && has_triangle_i) |=> in_stall_o)
    else $error("block ready right after a triangle transfer");

  // Only the three defined classifications appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (classification_o == CLASS_BOUNDARY || classification_o == CLASS_INSIDE ||
                     classification_o == CLASS_OUTSIDE))
    else $error("undefined classification");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(classification_o)))
    else $error("stalled result changed");

endmodule

bind point_in_mesh_ray_parity pimrp_chk u_pimrp_chk (.*);
